// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LengthBitsDefault = 64;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] MaskKeyBytes = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic [3:0] frame_opcode;
    logic       final_fragment;
  } result_t;

endpackage

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Tracks the frame header per byte and unmasks payload bytes.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t res_o
);

  wsd_pkg::phase_e         phase_q, phase_d;
  logic [3:0]              opcode_q, opcode_d;
  logic                    fin_q, fin_d;
  logic                    masked_q, masked_d;
  logic [3:0]              left_q, left_d;
  logic [LENGTH_BITS-1:0]  remaining_q, remaining_d;
  logic [31:0]             key_q, key_d;
  logic [1:0]              mask_pos_q, mask_pos_d;

  logic [LENGTH_BITS-1:0]  rem_dec;
  logic [3:0]              left_dec;
  logic [1:0]              key_slot;
  logic [7:0]              key_byte;

  assign rem_dec  = remaining_q - LENGTH_BITS'(1);
  assign left_dec = left_q - 4'd1;
  assign key_slot = 2'(wsd_pkg::MaskKeyBytes - left_q);
  assign key_byte = masked_q ? key_q[8*mask_pos_q +: 8] : 8'h00;

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    fin_d       = fin_q;
    masked_d    = masked_q;
    left_d      = left_q;
    remaining_d = remaining_q;
    key_d       = key_q;
    mask_pos_d  = mask_pos_q;
    res_valid_o = 1'b0;
    res_o.payload_byte   = in_byte_i ^ key_byte;
    res_o.last_of_frame  = (rem_dec == '0);
    res_o.frame_opcode   = opcode_q;
    res_o.final_fragment = fin_q;

    if (accept_i) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR1: begin
          masked_d = in_byte_i[7];
          if (in_byte_i[6:0] == wsd_pkg::Len7Ext16) begin
            remaining_d = '0;
            left_d      = wsd_pkg::Ext16Bytes;
            phase_d     = wsd_pkg::PH_EXTLEN;
          end else if (in_byte_i[6:0] == wsd_pkg::Len7Ext64) begin
            remaining_d = '0;
            left_d      = wsd_pkg::Ext64Bytes;
            phase_d     = wsd_pkg::PH_EXTLEN;
          end else begin
            remaining_d = LENGTH_BITS'(in_byte_i[6:0]);
            key_d       = '0;
            if (in_byte_i[7]) begin
              phase_d = wsd_pkg::PH_MASK;
              left_d  = wsd_pkg::MaskKeyBytes;
            end else begin
              mask_pos_d = 2'd0;
              phase_d    = (in_byte_i[6:0] == 7'd0) ? wsd_pkg::PH_HDR0
                                                    : wsd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          // An extended length wider than the counter saturates to all ones.
          if (remaining_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
            remaining_d = '1;
          end else begin
            remaining_d = {remaining_q[LENGTH_BITS-9:0], in_byte_i};
          end
          left_d = left_dec;
          if (left_dec == 4'd0) begin
            key_d = '0;
            if (masked_q) begin
              phase_d = wsd_pkg::PH_MASK;
              left_d  = wsd_pkg::MaskKeyBytes;
            end else begin
              mask_pos_d = 2'd0;
              phase_d    = (remaining_d == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsd_pkg::PH_MASK: begin
          key_d[8*key_slot +: 8] = key_q[8*key_slot +: 8] | in_byte_i;
          left_d = left_dec;
          if (left_dec == 4'd0) begin
            mask_pos_d = 2'd0;
            phase_d    = (remaining_q == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          res_valid_o = 1'b1;
          remaining_d = rem_dec;
          mask_pos_d  = mask_pos_q + 2'd1;
          if (rem_dec == '0) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          opcode_d = in_byte_i[3:0];
          fin_d    = in_byte_i[7];
          phase_d  = wsd_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PH_HDR0;
      opcode_q    <= '0;
      fin_q       <= 1'b0;
      masked_q    <= 1'b0;
      left_q      <= '0;
      remaining_q <= '0;
      key_q       <= '0;
      mask_pos_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      masked_q    <= masked_d;
      left_q      <= left_d;
      remaining_q <= remaining_d;
      key_q       <= key_d;
      mask_pos_q  <= mask_pos_d;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsd_pkg::PH_PAYLOAD |-> remaining_q != '0)
    else $error("payload phase with no bytes due");

  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsd_pkg::PH_MASK |-> (left_q != 4'd0 && left_q <= wsd_pkg::MaskKeyBytes))
    else $error("mask key byte count out of range");

  a_result_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (accept_i && phase_q == wsd_pkg::PH_PAYLOAD))
    else $error("result outside the payload phase");
`endif

endmodule

// ===== rtl/wsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer output buffer
// Output register with a skid stage that holds one more result under stall.
// ----------------------------------------------------------------------------
module wsd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsd_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output wsd_pkg::result_t m_data_o
);

  logic             main_valid_q, skid_valid_q;
  wsd_pkg::result_t main_q, skid_q;

  assign space_o   = !skid_valid_q;
  assign m_valid_o = main_valid_q;
  assign m_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (main_valid_q && m_ready_i) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= push_i;
        end
      end else if (!main_valid_q) begin
        main_valid_q <= push_i;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_valid_q && m_ready_i) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (!main_valid_q) begin
      if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid stage holds a result ahead of the output register");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_valid_q && !m_ready_i) |=> skid_valid_q)
    else $error("result dropped while the output was stalled");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_ready_i) |=> (m_valid_o && $stable(m_data_o)))
    else $error("output transfer changed while stalled");
`endif

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses back-to-back frames from a byte stream and emits unmasked payload.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  tdata          tuser                       tlast
//   s_axis    in         in_byte        -                           -
//   m_axis    out        payload_byte   frame_opcode, final_fragment  last_of_frame
//
// One stream byte is taken per cycle while s_axis_tready is high; the header
// phase update and the XOR unmask finish in that cycle and land in the output
// register, or in the skid stage while the output stalls. After reset the parser
// expects the first header byte of a frame. When the output stalls, one more
// result fits in the skid stage; s_axis_tready drops only while it is full.
//
module websocket_frame_deframer_top #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,
  output logic [4:0] m_axis_tuser    // [3:0] frame_opcode, [4] final_fragment
);

  logic             accept;
  logic             res_valid;
  logic             space;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_data;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (out_data)
  );

  assign m_axis_tdata = out_data.payload_byte;
  assign m_axis_tlast = out_data.last_of_frame;
  assign m_axis_tuser = {out_data.final_fragment, out_data.frame_opcode};

endmodule
